@@ rtl/dltcrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dltcrb_pkg;

   localparam int COORD_W     = 20;
   localparam int ENTRY_W     = 40;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int NUM_ENTRIES = 9;
   localparam int OUT_FRAC    = 8;
   localparam int REQ_TDATA_W = 4 * COORD_W;
   localparam int ROW_W       = 2;
   localparam int RSP_BITS    = ROW_W + NUM_ENTRIES * ENTRY_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [ENTRY_W-1:0] ONE_Q     = 40'sd256;
   localparam logic signed [ENTRY_W-1:0] MINUS_ONE = -40'sd256;

   localparam logic [ROW_W-1:0] ROW_A = 2'd0;
   localparam logic [ROW_W-1:0] ROW_B = 2'd1;
   localparam logic [ROW_W-1:0] ROW_C = 2'd2;

   typedef enum logic [1:0] {
      MODEL_SIM   = 2'd0,
      MODEL_AFF   = 2'd1,
      MODEL_PROJ2 = 2'd2,
      MODEL_PROJ3 = 2'd3
   } model_kind_type;

   typedef struct packed {
      model_kind_type            model;
      logic [ROW_W-1:0]          last_idx;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      logic signed [PROD_W-1:0]  pxx;
      logic signed [PROD_W-1:0]  pyx;
      logic signed [PROD_W-1:0]  pxy;
      logic signed [PROD_W-1:0]  pyy;
   } item_type;

endpackage

`default_nettype wire

@@ rtl/dltcrb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dltcrb_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [dltcrb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [1:0]                          csr_wr_data,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output dltcrb_pkg::item_type                     q_item
);

   logic                                    stage_valid_ff, stage_valid_in;
   logic signed [dltcrb_pkg::COORD_W-1:0]   sx_ff, sy_ff, dx_ff, dy_ff;
   dltcrb_pkg::model_kind_type              model_ff, model_in;
   dltcrb_pkg::model_kind_type              stage_model_ff;
   logic                                    req_take;

   assign req_tready = !stage_valid_ff || !q_full;
   assign req_take   = req_tvalid && req_tready;
   assign q_push     = stage_valid_ff && !q_full;

   always_comb begin
      model_in = model_ff;
      if (csr_wr_en) begin
         model_in = dltcrb_pkg::model_kind_type'(csr_wr_data);
      end
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff       <= dltcrb_pkg::MODEL_PROJ2;
         stage_valid_ff <= 1'b0;
      end else begin
         model_ff       <= model_in;
         stage_valid_ff <= stage_valid_in;
      end
      if (req_take) begin
         sx_ff          <= req_tdata[19:0];
         sy_ff          <= req_tdata[39:20];
         dx_ff          <= req_tdata[59:40];
         dy_ff          <= req_tdata[79:60];
         stage_model_ff <= model_ff;
      end
   end

   // The four cross products are formed here and registered by the queue.
   always_comb begin
      q_item.model    = stage_model_ff;
      q_item.last_idx = (stage_model_ff == dltcrb_pkg::MODEL_PROJ3) ?
                        dltcrb_pkg::ROW_C : dltcrb_pkg::ROW_B;
      q_item.sx       = sx_ff;
      q_item.sy       = sy_ff;
      q_item.dx       = dx_ff;
      q_item.dy       = dy_ff;
      q_item.pxx      = sx_ff * dx_ff;
      q_item.pyx      = sy_ff * dx_ff;
      q_item.pxy      = sx_ff * dy_ff;
      q_item.pyy      = sy_ff * dy_ff;
   end

endmodule

`default_nettype wire

@@ rtl/dltcrb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dltcrb_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dltcrb_pkg::item_type   push_item,
   input  wire logic                   pop,
   output logic                        full,
   output logic                        head_valid,
   output dltcrb_pkg::item_type        head_item
);

   dltcrb_pkg::item_type                  mem_ff [dltcrb_pkg::QUEUE_DEPTH];
   logic [dltcrb_pkg::PTR_W-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [dltcrb_pkg::CNT_W-1:0]          count_ff;

   assign full       = (count_ff == dltcrb_pkg::CNT_W'(dltcrb_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dltcrb_pkg::CNT_W'(dltcrb_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/dltcrb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dltcrb_back #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_valid,
   input  wire dltcrb_pkg::item_type                q_item,
   output logic                                     q_pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [dltcrb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int EW        = dltcrb_pkg::ENTRY_W;
   localparam int WW        = EW + 10;
   localparam int PROD_FRAC = 2 * COORD_FRAC_BITS;
   localparam int LIN_SHIFT = dltcrb_pkg::OUT_FRAC - COORD_FRAC_BITS;
   localparam int SHL = (PROD_FRAC <= dltcrb_pkg::OUT_FRAC) ?
                        dltcrb_pkg::OUT_FRAC - PROD_FRAC : 0;
   localparam int SHR = (PROD_FRAC > dltcrb_pkg::OUT_FRAC) ?
                        PROD_FRAC - dltcrb_pkg::OUT_FRAC : 1;
   localparam logic signed [WW-1:0] RND    = 50'sd1 <<< (SHR - 1);
   localparam logic signed [WW-1:0] SAT_HI = 50'sd274877906944;
   localparam logic signed [WW-1:0] SAT_LO = -50'sd274877906944;

   function automatic logic signed [EW-1:0] lin(
      input logic signed [dltcrb_pkg::COORD_W-1:0] c,
      input logic                                  neg
   );
      logic signed [EW-1:0] v;
      v = EW'(c);
      if (neg) begin
         v = -v;
      end
      return v <<< LIN_SHIFT;
   endfunction

   function automatic logic signed [EW-1:0] scale(
      input logic signed [dltcrb_pkg::PROD_W-1:0] p,
      input logic                                 neg
   );
      logic signed [WW-1:0] w;
      w = WW'(p);
      if (neg) begin
         w = -w;
      end
      if (PROD_FRAC <= dltcrb_pkg::OUT_FRAC) begin
         w = w <<< SHL;
      end else begin
         w = (w + RND) >>> SHR;
      end
      if (w > SAT_HI) begin
         w = SAT_HI;
      end else if (w < SAT_LO) begin
         w = SAT_LO;
      end
      return w[EW-1:0];
   endfunction

   logic [dltcrb_pkg::ROW_W-1:0]                      row_cnt_ff;
   logic [dltcrb_pkg::ROW_W-1:0]                      row_ff;
   logic                                              valid_ff, last_ff;
   logic [dltcrb_pkg::NUM_ENTRIES-1:0][EW-1:0]        ent_ff;
   logic [dltcrb_pkg::NUM_ENTRIES-1:0][EW-1:0]        ent_in;
   logic                                              load, row_done;

   assign load     = q_valid && (!valid_ff || rsp_tready);
   assign row_done = (row_cnt_ff == q_item.last_idx);
   assign q_pop    = load && row_done;

   always_comb begin
      ent_in = '0;
      case (q_item.model)
         dltcrb_pkg::MODEL_SIM: begin
            if (row_cnt_ff == dltcrb_pkg::ROW_A) begin
               ent_in[0] = lin(q_item.sx, 1'b0);
               ent_in[1] = lin(q_item.sy, 1'b0);
               ent_in[2] = dltcrb_pkg::ONE_Q;
               ent_in[4] = lin(q_item.dx, 1'b1);
            end else begin
               ent_in[0] = lin(q_item.sy, 1'b1);
               ent_in[1] = lin(q_item.sx, 1'b0);
               ent_in[3] = dltcrb_pkg::MINUS_ONE;
               ent_in[4] = lin(q_item.dy, 1'b0);
            end
         end
         dltcrb_pkg::MODEL_AFF: begin
            if (row_cnt_ff == dltcrb_pkg::ROW_A) begin
               ent_in[0] = lin(q_item.sx, 1'b1);
               ent_in[1] = lin(q_item.sy, 1'b1);
               ent_in[2] = dltcrb_pkg::MINUS_ONE;
               ent_in[6] = lin(q_item.dx, 1'b0);
            end else begin
               ent_in[3] = lin(q_item.sx, 1'b1);
               ent_in[4] = lin(q_item.sy, 1'b1);
               ent_in[5] = dltcrb_pkg::MINUS_ONE;
               ent_in[6] = lin(q_item.dy, 1'b0);
            end
         end
         default: begin
            case (row_cnt_ff)
               dltcrb_pkg::ROW_A: begin
                  ent_in[0] = lin(q_item.sx, 1'b0);
                  ent_in[1] = lin(q_item.sy, 1'b0);
                  ent_in[2] = dltcrb_pkg::ONE_Q;
                  ent_in[6] = scale(q_item.pxx, 1'b1);
                  ent_in[7] = scale(q_item.pyx, 1'b1);
                  ent_in[8] = lin(q_item.dx, 1'b1);
               end
               dltcrb_pkg::ROW_B: begin
                  ent_in[3] = lin(q_item.sx, 1'b0);
                  ent_in[4] = lin(q_item.sy, 1'b0);
                  ent_in[5] = dltcrb_pkg::ONE_Q;
                  ent_in[6] = scale(q_item.pxy, 1'b1);
                  ent_in[7] = scale(q_item.pyy, 1'b1);
                  ent_in[8] = lin(q_item.dy, 1'b1);
               end
               default: begin
                  ent_in[0] = scale(q_item.pxy, 1'b1);
                  ent_in[1] = scale(q_item.pyy, 1'b1);
                  ent_in[2] = lin(q_item.dy, 1'b1);
                  ent_in[3] = scale(q_item.pxx, 1'b0);
                  ent_in[4] = scale(q_item.pyx, 1'b0);
                  ent_in[5] = lin(q_item.dx, 1'b0);
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         row_cnt_ff <= dltcrb_pkg::ROW_A;
      end else begin
         if (load) begin
            valid_ff   <= 1'b1;
            row_cnt_ff <= row_done ? dltcrb_pkg::ROW_A : row_cnt_ff + 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
      if (load) begin
         ent_ff  <= ent_in;
         row_ff  <= row_cnt_ff;
         last_ff <= row_done;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{dltcrb_pkg::RSP_PAD_W{1'b0}}, ent_ff, row_ff};

   a_last_not_first: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> row_ff != dltcrb_pkg::ROW_A)
      else $error("final row flagged on the first row");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> row_cnt_ff <= q_item.last_idx)
      else $error("row counter beyond the item's last row");

   a_row_sequence: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !last_ff |=>
         !valid_ff || row_ff == $past(row_ff) + 2'd1)
      else $error("rows of an item out of sequence");

endmodule

`default_nettype wire

@@ rtl/dlt_constraint_row_builder_top.sv @@
// Direct linear transform constraint row builder.
// The request channel carries one point correspondence per item; the response
// channel returns its constraint rows, one row per transfer, and rsp_tlast
// is high on the final row. The model is set through csr_wr_en/csr_wr_data
// (0 similarity, 1 affine, 2 projective with two rows, 3 with three rows) and
// is sampled when a correspondence is accepted.
// A correspondence accepted on the request channel passes the input stage
// register, the queue memory and the output register before its first row
// appears on rsp_tvalid; its rows follow at one per cycle while rsp_tready is
// high. A correspondence gives two rows, or three in the three-row model.
// An input stage and a two-entry queue sit in front of the row sequencer, so
// further correspondences are taken while rows wait at the output.
// When rsp_tready is low the current row holds, the queue fills, and then
// req_tready falls. Synchronous reset empties the pipeline and sets the model
// to projective with two rows.
`timescale 1ns / 1ps
`default_nettype none

module dlt_constraint_row_builder_top #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // src_x, src_y, dst_x, dst_y
   input  wire logic [dltcrb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // row_index, entry0 .. entry8, zero padding
   output logic [dltcrb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_wr_en,
   input  wire logic [1:0]                          csr_wr_data
);

   dltcrb_pkg::item_type push_item, head_item;
   logic                 q_full, q_push, q_pop, q_valid;

   dltcrb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   dltcrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   dltcrb_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ verif/dlt_constraint_row_checker.sv @@
`timescale 1ns / 1ps

module dlt_constraint_row_checker #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dltcrb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dltcrb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_wr_data,
   output int                                  pending_rows,
   output int                                  mismatch_count
);
   import dltcrb_pkg::*;

   localparam longint ENTRY_LIMIT = 64'sd1 <<< 38;

   typedef struct packed {
      logic [ROW_W-1:0]                    row_index;
      logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] entries;
      logic                                last_row;
   } constraint_row_type;

   constraint_row_type expected_rows[$];
   model_kind_type     model_now = MODEL_PROJ2;
   int                 errors = 0;

   initial begin
      pending_rows = 0;
      mismatch_count = 0;
   end

   function automatic longint clamp_entry(longint v);
      if (v > ENTRY_LIMIT) return ENTRY_LIMIT;
      if (v < -ENTRY_LIMIT) return -ENTRY_LIMIT;
      return v;
   endfunction

   function automatic longint rescale_to_q8(longint v, int frac);
      int     shift;
      longint bound;
      if (frac <= OUT_FRAC) begin
         shift = OUT_FRAC - frac;
         bound = (64'sd1 <<< 39) >>> shift;
         if (v > bound) return ENTRY_LIMIT;
         if (v < -bound) return -ENTRY_LIMIT;
         return clamp_entry(v <<< shift);
      end
      shift = frac - OUT_FRAC;
      return clamp_entry((v + (64'sd1 <<< (shift - 1))) >>> shift);
   endfunction

   function automatic longint coord_term(longint a, bit negate);
      return rescale_to_q8(negate ? -a : a, COORD_FRAC_BITS);
   endfunction

   function automatic longint product_term(longint a, longint b, bit negate);
      return rescale_to_q8(negate ? -(a * b) : a * b, 2 * COORD_FRAC_BITS);
   endfunction

   function automatic constraint_row_type pack_row(int idx, bit last, longint e[9]);
      constraint_row_type r;
      r.row_index = idx[ROW_W-1:0];
      for (int j = 0; j < NUM_ENTRIES; j++) r.entries[j] = e[j][ENTRY_W-1:0];
      r.last_row = last;
      return r;
   endfunction

   function automatic void predict_rows(logic [REQ_TDATA_W-1:0] pair, model_kind_type model);
      longint sx, sy, dx, dy;
      longint ra[9], rb[9], rc[9];
      sx = $signed(pair[0 +: COORD_W]);
      sy = $signed(pair[COORD_W +: COORD_W]);
      dx = $signed(pair[2 * COORD_W +: COORD_W]);
      dy = $signed(pair[3 * COORD_W +: COORD_W]);
      ra = '{default: 0};
      rb = '{default: 0};
      rc = '{default: 0};
      case (model)
         MODEL_SIM: begin
            ra[0] = coord_term(sx, 1'b0);
            ra[1] = coord_term(sy, 1'b0);
            ra[2] = ONE_Q;
            ra[4] = coord_term(dx, 1'b1);
            rb[0] = coord_term(sy, 1'b1);
            rb[1] = coord_term(sx, 1'b0);
            rb[3] = MINUS_ONE;
            rb[4] = coord_term(dy, 1'b0);
            expected_rows.push_back(pack_row(ROW_A, 1'b0, ra));
            expected_rows.push_back(pack_row(ROW_B, 1'b1, rb));
         end
         MODEL_AFF: begin
            ra[0] = coord_term(sx, 1'b1);
            ra[1] = coord_term(sy, 1'b1);
            ra[2] = MINUS_ONE;
            ra[6] = coord_term(dx, 1'b0);
            rb[3] = coord_term(sx, 1'b1);
            rb[4] = coord_term(sy, 1'b1);
            rb[5] = MINUS_ONE;
            rb[6] = coord_term(dy, 1'b0);
            expected_rows.push_back(pack_row(ROW_A, 1'b0, ra));
            expected_rows.push_back(pack_row(ROW_B, 1'b1, rb));
         end
         default: begin
            ra[0] = coord_term(sx, 1'b0);
            ra[1] = coord_term(sy, 1'b0);
            ra[2] = ONE_Q;
            ra[6] = product_term(sx, dx, 1'b1);
            ra[7] = product_term(sy, dx, 1'b1);
            ra[8] = coord_term(dx, 1'b1);
            rb[3] = coord_term(sx, 1'b0);
            rb[4] = coord_term(sy, 1'b0);
            rb[5] = ONE_Q;
            rb[6] = product_term(sx, dy, 1'b1);
            rb[7] = product_term(sy, dy, 1'b1);
            rb[8] = coord_term(dy, 1'b1);
            expected_rows.push_back(pack_row(ROW_A, 1'b0, ra));
            if (model == MODEL_PROJ2) begin
               expected_rows.push_back(pack_row(ROW_B, 1'b1, rb));
            end else begin
               rc[0] = product_term(sx, dy, 1'b1);
               rc[1] = product_term(sy, dy, 1'b1);
               rc[2] = coord_term(dy, 1'b1);
               rc[3] = product_term(sx, dx, 1'b0);
               rc[4] = product_term(sy, dx, 1'b0);
               rc[5] = coord_term(dx, 1'b0);
               expected_rows.push_back(pack_row(ROW_B, 1'b0, rb));
               expected_rows.push_back(pack_row(ROW_C, 1'b1, rc));
            end
         end
      endcase
   endfunction

   function automatic void report(string field, longint want, longint got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   function automatic void compare_row(constraint_row_type want, constraint_row_type seen);
      longint e_want, e_seen;
      if (want.row_index != seen.row_index)
         report("row_index", want.row_index, seen.row_index);
      for (int j = 0; j < NUM_ENTRIES; j++) begin
         e_want = $signed(want.entries[j]);
         e_seen = $signed(seen.entries[j]);
         if (e_want != e_seen) report($sformatf("entry%0d", j), e_want, e_seen);
      end
      if (want.last_row != seen.last_row)
         report("last_row", want.last_row, seen.last_row);
   endfunction

   always @(posedge clock) begin
      constraint_row_type seen;
      if (reset) begin
         model_now = MODEL_PROJ2;
         expected_rows.delete();
      end else begin
         if (csr_wr_en) model_now = model_kind_type'(csr_wr_data);
         if (rsp_tvalid && rsp_tready) begin
            seen.row_index = rsp_tdata[ROW_W-1:0];
            seen.entries = rsp_tdata[ROW_W +: NUM_ENTRIES * ENTRY_W];
            seen.last_row = rsp_tlast;
            if (expected_rows.size() == 0) begin
               errors++;
               $display("%0t ns: row_index mismatch, expected no row, actual %0d",
                        $time, seen.row_index);
            end else begin
               compare_row(expected_rows.pop_front(), seen);
            end
         end
         if (req_tvalid && req_tready) predict_rows(req_tdata, model_now);
      end
      pending_rows <= expected_rows.size();
      mismatch_count <= errors;
   end

endmodule

@@ verif/dlt_constraint_row_builder_top_test.sv @@
`timescale 1ns / 1ps

module dlt_constraint_row_builder_top_test;
   import dltcrb_pkg::*;

   localparam int FRAC = 4;
   localparam logic [COORD_W-1:0] COORD_MAX = 20'h7FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 20'h80000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wr_en = 1'b0;
   logic [1:0]             csr_wr_data = '0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire                    rsp_tlast;
   wire [RSP_TDATA_W-1:0]  rsp_tdata;
   int                     pending_rows;
   int                     mismatch_count;
   int                     send_quiet = 0;
   int                     take_quiet = 0;

   always #1 clock = ~clock;

   dlt_constraint_row_builder_top #(.COORD_FRAC_BITS(FRAC)) u_dut (.*);

   dlt_constraint_row_checker #(.COORD_FRAC_BITS(FRAC)) u_checker (.*);

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return COORD_W'($urandom_range(0, 64) - 32);
         default: return COORD_W'($urandom());
      endcase
   endfunction

   task automatic send_pair(input logic [COORD_W-1:0] sx, sy, dx, dy);
      int gap;
      if (send_quiet > 0) begin
         send_quiet--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 18);
         if ($urandom_range(0, 39) == 0) send_quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dy, dx, sy, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
   endtask

   task automatic write_model(input model_kind_type model);
      csr_wr_en <= 1'b1;
      csr_wr_data <= model;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_corner_pairs();
      send_pair('0, '0, '0, '0);
      send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_pair('1, 20'd1, COORD_MIN, COORD_MAX);
   endtask

   initial begin : row_sink
      int hold;
      forever begin
         if (take_quiet > 0) begin
            take_quiet--;
            hold = 0;
         end else begin
            hold = $urandom_range(0, 18);
            if ($urandom_range(0, 39) == 0) take_quiet = $urandom_range(10, 40);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : watchdog
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      model_kind_type corner_models[3] = '{MODEL_SIM, MODEL_AFF, MODEL_PROJ3};
      model_kind_type phase_models[8] = '{MODEL_PROJ3, MODEL_AFF, MODEL_SIM, MODEL_PROJ2,
                                          MODEL_SIM, MODEL_PROJ3, MODEL_AFF, MODEL_PROJ2};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The model after reset is projective with two rows.
      send_corner_pairs();
      foreach (corner_models[m]) begin
         wait_idle();
         write_model(corner_models[m]);
         send_corner_pairs();
      end
      foreach (phase_models[p]) begin
         wait_idle();
         write_model(phase_models[p]);
         repeat (35) send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_rows == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
